FILE: sv/bpc_pkg.sv
// shared types, register indexes and constants for the button press classifier
package bpc_pkg;

  // number of button inputs wired to the block
  localparam int unsigned NUM_BUTTONS = 8;
  // widest usable button count, limited by the 8-bit level field
  localparam int unsigned BTN_LIMIT = (NUM_BUTTONS < 8) ? NUM_BUTTONS : 8;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BUTTON_COUNT = 2'd0,
    CFG_DEBOUNCE_MS  = 2'd1,
    CFG_LONG_MS      = 2'd2,
    CFG_REPEAT_MS    = 2'd3
  } cfg_reg_t;

  // request codes carried by an input transaction
  typedef enum logic [1:0] {
    REQ_PEEK  = 2'd0,
    REQ_TAKE  = 2'd1,
    REQ_FLUSH = 2'd2
  } req_t;

  // configuration reset values
  localparam logic [3:0]  RST_BUTTON_COUNT = 4'd8;
  localparam logic [15:0] RST_DEBOUNCE_MS  = 16'd50;
  localparam logic [15:0] RST_LONG_MS      = 16'd1000;
  localparam logic [15:0] RST_REPEAT_MS    = 16'd200;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  pin_levels;
    logic [31:0] now_ms;
  } bpc_in_t;

  typedef struct packed {
    logic [7:0] event_buttons;
    logic       long_press;
    logic       repeat_press;
  } bpc_out_t;

endpackage

FILE: sv/button_press_classifier.sv
// top level of the button press classifier
//
// Takes one transaction per clock cycle while results drain and returns exactly one
// result per transaction, in order. An accepted transaction is captured in the
// input register; the classify step (mask, 32-bit wrapping elapsed time, three
// compares, state update) then runs on it and loads the result register when
// that register is free or being taken. The state update of the classify stage
// is registered together with the result, so the next transaction sees it
// directly. Both registers move whenever the result register is free or
// being taken, so the block takes a new transaction each cycle in which
// results drain. Configuration writes take effect at once; the user must make
// them while no transaction is in flight, which the block itself does not enforce.
module button_press_classifier
  import bpc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  bpc_in_t                in_data,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output bpc_out_t               out_data,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  logic [3:0]  button_count;
  logic [15:0] debounce_ms;
  logic [15:0] long_ms;
  logic [15:0] repeat_ms;

  // classifier state
  logic [7:0]  last_combo,      last_combo_next;
  logic [31:0] mark_time,       mark_time_next;
  logic        may_emit,        may_emit_next;
  logic [7:0]  pending_buttons, pending_buttons_next;
  logic        pending_long,    pending_long_next;
  logic        pending_repeat,  pending_repeat_next;

  // pipeline registers
  logic        s1_valid;
  bpc_in_t     s1_data;
  bpc_out_t    result_next;

  logic        advance;
  logic [3:0]  count_sat;
  logic [8:0]  low_mask;
  logic [7:0]  combo;
  logic [31:0] elapsed;
  logic        gt_debounce;
  logic        gt_long;
  logic        gt_repeat;
  logic        can_post;

  // pipeline moves whenever the result register is free or being taken
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      button_count <= RST_BUTTON_COUNT;
      debounce_ms  <= RST_DEBOUNCE_MS;
      long_ms      <= RST_LONG_MS;
      repeat_ms    <= RST_REPEAT_MS;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_BUTTON_COUNT: button_count <= cfg_data[3:0];
        CFG_DEBOUNCE_MS:  debounce_ms  <= cfg_data;
        CFG_LONG_MS:      long_ms      <= cfg_data;
        CFG_REPEAT_MS:    repeat_ms    <= cfg_data;
        default:          ;
      endcase
    end
  end

  // pressed mask over the buttons in use
  assign count_sat = (button_count > 4'(BTN_LIMIT)) ? 4'(BTN_LIMIT) : button_count;
  assign low_mask  = (9'd1 << count_sat) - 9'd1;
  assign combo     = ~s1_data.pin_levels & low_mask[7:0];

  // wrapping elapsed time and limit compares
  assign elapsed     = s1_data.now_ms - mark_time;
  assign gt_debounce = elapsed > {16'd0, debounce_ms};
  assign gt_long     = elapsed > {16'd0, long_ms};
  assign gt_repeat   = elapsed > {16'd0, repeat_ms};
  assign can_post    = (pending_buttons == 8'd0);

  // classify step
  always_comb begin
    last_combo_next      = last_combo;
    mark_time_next       = mark_time;
    may_emit_next        = may_emit;
    pending_buttons_next = pending_buttons;
    pending_long_next    = pending_long;
    pending_repeat_next  = pending_repeat;

    if (req_t'(s1_data.req_type) == REQ_FLUSH) begin
      last_combo_next      = 8'd0;
      may_emit_next        = 1'b1;
      pending_buttons_next = 8'd0;
      pending_long_next    = 1'b0;
      pending_repeat_next  = 1'b0;
      mark_time_next       = s1_data.now_ms;
    end else if (combo == last_combo) begin
      // held combination: repeat after a long press, else a first long press
      if (gt_repeat && !may_emit && (combo != 8'd0)) begin
        if (can_post) begin
          pending_buttons_next = combo;
          pending_long_next    = 1'b0;
          pending_repeat_next  = 1'b1;
        end
        mark_time_next = s1_data.now_ms;
      end else if (gt_long && may_emit && (combo != 8'd0)) begin
        if (can_post) begin
          pending_buttons_next = combo;
          pending_long_next    = 1'b1;
          pending_repeat_next  = 1'b0;
        end
        mark_time_next = s1_data.now_ms;
        may_emit_next  = 1'b0;
      end
    end else begin
      // combination changed: short press of the previous one
      if (gt_debounce && may_emit && (last_combo != 8'd0) && can_post) begin
        pending_buttons_next = last_combo;
        pending_long_next    = 1'b0;
        pending_repeat_next  = 1'b0;
      end
      may_emit_next   = 1'b1;
      last_combo_next = combo;
      mark_time_next  = s1_data.now_ms;
    end

    result_next.event_buttons = pending_buttons_next;
    result_next.long_press    = pending_long_next;
    result_next.repeat_press  = pending_repeat_next;

    // take request clears the event after it is reported
    if (req_t'(s1_data.req_type) == REQ_TAKE) begin
      pending_buttons_next = 8'd0;
      pending_long_next    = 1'b0;
      pending_repeat_next  = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  // state update and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      last_combo      <= 8'd0;
      mark_time       <= 32'd0;
      may_emit        <= 1'b1;
      pending_buttons <= 8'd0;
      pending_long    <= 1'b0;
      pending_repeat  <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        last_combo      <= last_combo_next;
        mark_time       <= mark_time_next;
        may_emit        <= may_emit_next;
        pending_buttons <= pending_buttons_next;
        pending_long    <= pending_long_next;
        pending_repeat  <= pending_repeat_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_data <= result_next;
    end
  end

endmodule

FILE: sv/bpc_checker.sv
// port-level assertions for the button press classifier, with its bind
module bpc_checker
  import bpc_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input bpc_in_t                in_data,
  input logic                   out_valid,
  input logic                   out_ready,
  input bpc_out_t               out_data
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // an event is never both long press and repeat
  a_kind_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.long_press && out_data.repeat_press))
    else $error("long press and repeat both set");

  // an event kind always comes with a button mask
  a_kind_has_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.long_press || out_data.repeat_press)
      |-> out_data.event_buttons != 8'd0)
    else $error("event kind without buttons");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a stalled input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("stalled input transaction changed");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (.*);

FILE: tb/sv/tb_button_press_classifier.sv
// self-checking testbench for the button press classifier
module tb_button_press_classifier;
  import bpc_pkg::*;

  // request code left unused by the block, handled like a peek
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  bpc_in_t                in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  bpc_out_t               out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // mirror of the configuration registers
  logic [3:0]  btn_count   = RST_BUTTON_COUNT;
  logic [15:0] debounce_ms = RST_DEBOUNCE_MS;
  logic [15:0] long_ms     = RST_LONG_MS;
  logic [15:0] repeat_ms   = RST_REPEAT_MS;

  // mirror of the classifier state
  logic [7:0]  held_combo = '0;
  logic [31:0] mark_ms    = '0;
  logic        may_emit   = 1'b1;
  logic [7:0]  ev_buttons = '0;
  logic        ev_long    = 1'b0;
  logic        ev_repeat  = 1'b0;

  // events the block must report, oldest first
  bpc_out_t    expected_events[$];

  int          fail_count    = 0;
  int unsigned items_sent    = 0;
  int unsigned burst_left    = 0;
  bit          gaps_on       = 1'b1;
  // number of long hold-offs asked of the receiver
  int unsigned hold_request  = 0;
  logic [31:0] clock_ms      = '0;

  button_press_classifier DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // a new event is dropped while one is pending
  function automatic void latch_event(input logic [7:0] mask, input logic is_long,
                                      input logic is_rep);
    if (ev_buttons == 8'd0) begin
      ev_buttons = mask;
      ev_long    = is_long;
      ev_repeat  = is_rep;
    end
  endfunction

  // classify one sample and return the event shown for it
  function automatic bpc_out_t classify_sample(input bpc_in_t item);
    bpc_out_t    res;
    logic [3:0]  n;
    logic [8:0]  lane_mask;
    logic [7:0]  combo;
    logic [31:0] elapsed;
    if (item.req_type == REQ_FLUSH) begin
      held_combo = '0;
      may_emit   = 1'b1;
      ev_buttons = '0;
      ev_long    = 1'b0;
      ev_repeat  = 1'b0;
      mark_ms    = item.now_ms;
    end else begin
      n = (btn_count > BTN_LIMIT) ? 4'(BTN_LIMIT) : btn_count;
      lane_mask = (9'd1 << n) - 9'd1;
      combo = ~item.pin_levels & lane_mask[7:0];
      elapsed = item.now_ms - mark_ms;
      if (combo == held_combo) begin
        // same combination held: repeat after a long press, else long press
        if (elapsed > {16'd0, repeat_ms} && !may_emit && combo != 8'd0) begin
          latch_event(combo, 1'b0, 1'b1);
          mark_ms = item.now_ms;
        end else if (elapsed > {16'd0, long_ms} && may_emit && combo != 8'd0) begin
          latch_event(combo, 1'b1, 1'b0);
          mark_ms  = item.now_ms;
          may_emit = 1'b0;
        end
      end else begin
        // combination changed: short press of the old one if held long enough
        if (elapsed > {16'd0, debounce_ms} && may_emit && held_combo != 8'd0)
          latch_event(held_combo, 1'b0, 1'b0);
        may_emit   = 1'b1;
        held_combo = combo;
        mark_ms    = item.now_ms;
      end
    end
    res.event_buttons = ev_buttons;
    res.long_press    = ev_long;
    res.repeat_press  = ev_repeat;
    if (item.req_type == REQ_TAKE) begin
      ev_buttons = '0;
      ev_long    = 1'b0;
      ev_repeat  = 1'b0;
    end
    return res;
  endfunction

  // offer one transaction, with a random gap between bursts if gaps are on
  task automatic send_item(input logic [1:0] req, input logic [7:0] levels,
                           input logic [31:0] now);
    bpc_in_t     item;
    int unsigned gap;
    item.req_type   = req;
    item.pin_levels = levels;
    item.now_ms     = now;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gaps_on && gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_events.push_back(classify_sample(item));
    items_sent++;
  endtask

  // stop offering and let every result and the pipeline drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all four registers while the block is idle
  task automatic configure(input logic [15:0] count, input logic [15:0] deb,
                           input logic [15:0] hold, input logic [15:0] rep);
    cfg_reg_t    idx;
    logic [15:0] val;
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      case (i)
        0:       begin idx = CFG_BUTTON_COUNT; val = count; end
        1:       begin idx = CFG_DEBOUNCE_MS;  val = deb;   end
        2:       begin idx = CFG_LONG_MS;      val = hold;  end
        default: begin idx = CFG_REPEAT_MS;    val = rep;   end
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      @(posedge clk);
      case (idx)
        CFG_BUTTON_COUNT: btn_count   = val[3:0];
        CFG_DEBOUNCE_MS:  debounce_ms = val;
        CFG_LONG_MS:      long_ms     = val;
        default:          repeat_ms   = val;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // mostly peeks, with takes, the unused code and a few flushes
  function automatic logic [1:0] pick_req();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return REQ_PEEK;
    if (r < 85) return REQ_TAKE;
    if (r < 93) return REQ_UNUSED;
    return REQ_FLUSH;
  endfunction

  // time step, often landing on or just past a threshold
  function automatic logic [31:0] pick_delta(input logic [31:0] span);
    case ($urandom_range(0, 9))
      0:       return {16'd0, debounce_ms};
      1:       return {16'd0, debounce_ms} + 32'd1;
      2:       return {16'd0, repeat_ms};
      3:       return {16'd0, repeat_ms} + 32'd1;
      4:       return {16'd0, long_ms} + 32'd1;
      default: return $urandom_range(0, span);
    endcase
  endfunction

  // press a combination, hold it for a few samples, then release or change
  task automatic play_gesture();
    logic [7:0]  held;
    logic [31:0] span;
    int unsigned holds;
    if ($urandom_range(0, 9) == 0) begin
      // noise: any request, any levels, a jump in time
      clock_ms = $urandom();
      send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), clock_ms);
    end else begin
      held = ($urandom_range(0, 1) == 0) ? 8'(1 << $urandom_range(0, 7))
                                         : 8'($urandom_range(1, 255));
      span = {16'd0, long_ms} / 4 + {16'd0, repeat_ms} + {16'd0, debounce_ms} + 32'd2;
      holds = $urandom_range(1, 10);
      for (int i = 0; i < holds; i++) begin
        clock_ms += pick_delta(span);
        send_item(pick_req(), ~held, clock_ms);
      end
      clock_ms += pick_delta(span);
      if ($urandom_range(0, 3) == 0)
        send_item(pick_req(), 8'($urandom_range(0, 255)), clock_ms);
      else
        send_item(pick_req(), 8'hFF, clock_ms);
    end
  endtask

  // hand-picked sequences under the reset configuration
  task automatic test_directed();
    send_item(REQ_PEEK, 8'hFF, 32'd0);
    send_item(REQ_PEEK, 8'hFE, 32'd10);
    send_item(REQ_PEEK, 8'hFE, 32'd60);
    // released just past the debounce time: short press
    send_item(REQ_PEEK, 8'hFF, 32'd61);
    send_item(REQ_TAKE, 8'hFF, 32'd70);
    send_item(REQ_PEEK, 8'h00, 32'd100);
    // long press exactly at the limit and just past it
    send_item(REQ_PEEK, 8'h00, 32'd1100);
    send_item(REQ_TAKE, 8'h00, 32'd1101);
    send_item(REQ_PEEK, 8'h00, 32'd1301);
    send_item(REQ_PEEK, 8'h00, 32'd1302);
    // second repeat dropped while the first is pending
    send_item(REQ_PEEK, 8'h00, 32'd1600);
    send_item(REQ_TAKE, 8'h00, 32'd1601);
    // release after a long press gives no short press
    send_item(REQ_PEEK, 8'hFF, 32'd1700);
    send_item(REQ_PEEK, 8'h55, 32'd1800);
    send_item(REQ_PEEK, 8'hAA, 32'd1900);
    send_item(REQ_PEEK, 8'hFF, 32'd2000);
    send_item(REQ_UNUSED, 8'hFF, 32'd2001);
    // flush near the top of the time range, then wrap around
    send_item(REQ_FLUSH, 8'h00, 32'hFFFF_FFF0);
    send_item(REQ_PEEK, 8'h7F, 32'h0000_0010);
    send_item(REQ_PEEK, 8'hFF, 32'h0000_0100);
    send_item(REQ_TAKE, 8'hFF, 32'hFFFF_FFFF);
  endtask

  // zero, oversized and partial button counts with extreme time limits
  task automatic test_button_count();
    configure(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(REQ_PEEK, 8'h00, 32'd5);
    send_item(REQ_TAKE, 8'h00, 32'd10);
    configure(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    send_item(REQ_PEEK, 8'h00, 32'd20);
    send_item(REQ_TAKE, 8'h00, 32'd21);
    configure(16'hFFF3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(REQ_PEEK, 8'h00, 32'd30);
    send_item(REQ_TAKE, 8'h00, 32'd30 + 32'd65536);
  endtask

  // random gestures over several configurations, fixed and extreme ones first
  task automatic test_random_gestures();
    int unsigned stop_at;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: configure(16'd8, 16'd50, 16'd1000, 16'd200);
        1: configure(16'd0, 16'd0, 16'd0, 16'd0);
        2: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: configure(16'd8, 16'd0, 16'd0, 16'd0);
        default: configure(16'($urandom_range(0, 15)), 16'($urandom_range(0, 40)),
                           16'($urandom_range(0, 300)), 16'($urandom_range(0, 80)));
      endcase
      clock_ms = $urandom();
      stop_at = items_sent + ((phase == 1) ? 60 : 230);
      while (items_sent < stop_at) play_gesture();
    end
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    int unsigned stop_at;
    configure(16'd8, 16'd5, 16'd40, 16'd10);
    gaps_on = 1'b0;
    hold_request++;
    stop_at = items_sent + 40;
    while (items_sent < stop_at) play_gesture();
    gaps_on = 1'b1;
  endtask

  // result side stall pattern
  initial begin : receiver
    int unsigned stretch;
    int unsigned mode;
    int unsigned holds_done = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stretch = $urandom_range(10, 120);
      mode = $urandom_range(0, 2);
      for (int k = 0; k < stretch; k++) begin
        if (hold_request != holds_done) begin
          // long hold-off so the block fills and stalls its input
          out_ready <= 1'b0;
          repeat (80) @(posedge clk);
          holds_done++;
        end
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (k % 7) > 2;
        endcase
        @(posedge clk);
      end
    end
  end

  // compare each result transaction with the oldest expected event
  always @(posedge clk) begin : result_check
    bpc_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        $error("unexpected result transaction %h", out_data);
        fail_count++;
      end else begin
        want = expected_events.pop_front();
        if (out_data.event_buttons !== want.event_buttons) begin
          $error("event_buttons: expected %h, actual %h", want.event_buttons,
                 out_data.event_buttons);
          fail_count++;
        end
        if (out_data.long_press !== want.long_press) begin
          $error("long_press: expected %b, actual %b", want.long_press,
                 out_data.long_press);
          fail_count++;
        end
        if (out_data.repeat_press !== want.repeat_press) begin
          $error("repeat_press: expected %b, actual %b", want.repeat_press,
                 out_data.repeat_press);
          fail_count++;
        end
      end
    end
  end

  // test sequence
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_button_count();
    test_random_gestures();
    test_backpressure();
    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
